[sv/pcxrle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_pkg
// shared types and constants of the run-length pixel decoder
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_COUNT_BITS      = 24;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // run marker: both top bits set, low six bits give the length
  localparam logic [7:0] RUN_MARK = 8'hc0;
  localparam logic [7:0] RUN_LEN  = 8'h3f;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCANLINE_BYTES = 2'd0,
    CFG_IMAGE_WIDTH    = 2'd1,
    CFG_TOTAL_BYTES    = 2'd2,
    CFG_PALETTE_MODE   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  stream_byte;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
  } in_beat_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic        last;
    logic        image_done;
  } out_beat_t;

endpackage

[sv/pcx_rle_pixel_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_top
// run-length pixel decoder with scanline padding drop and colour palette
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one beat per encoded byte (command 0) or palette write (command 1)
//   out_* : one beat per kept pixel, last marks the final beat of an input
//           beat, image_done marks the beat that completes total_bytes
//   cfg_* : plain register writes, only while the block is idle
// sequence:
//   a palette write, a run marker or a byte after completion is taken in idle
//   and starts no expansion. a literal byte is accepted, then takes one column
//   step and a final push; a run data byte takes one step per run count and
//   a final push. one shared column and count step unit serves each step, so
//   with input stalled a run expands one byte per cycle unless out_stall holds it
// stall:
//   a single output register holds the waiting beat; the step sequencer keeps
//   one kept pixel in hand and only advances past another kept pixel when the
//   output register can take the held one, so a receiver stall freezes the
//   run expansion without loss
// reset:
//   synchronous, active low. clears run state, column, counters and config
//   to their defaults; palette contents are undefined until written
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder_top #(
  parameter int PALETTE_ENTRIES = pcxrle_pkg::DEF_PALETTE_ENTRIES,
  parameter int COUNT_BITS      = pcxrle_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcxrle_pkg::in_beat_t               in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcxrle_pkg::out_beat_t              out_data,
  // configuration
  input  logic                               cfg_we,
  input  logic [pcxrle_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  // config registers
  logic [15:0] scanline_bytes_r;
  logic [15:0] image_width_r;
  logic [23:0] total_bytes_r;
  logic        palette_mode_r;

  // control state
  pcxrle_pkg::state_t state_r, state_nxt;
  logic                  run_pending_r, run_pending_nxt;
  logic [5:0]            run_count_r, run_count_nxt;
  logic [15:0]           column_r, column_nxt;
  logic [COUNT_BITS-1:0] kept_count_r, kept_count_nxt;
  logic                  finished_r, finished_nxt;
  logic [5:0]            rem_r, rem_nxt;
  logic                  cand_valid_r, cand_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload
  logic                  cand_done_r, cand_done_nxt;
  logic [7:0]            byte_r;
  logic [23:0]           rd_r;
  pcxrle_pkg::out_beat_t out_data_r, out_data_nxt;

  logic [23:0] palette_mem [PALETTE_ENTRIES];

  logic in_accept;
  logic is_marker;
  logic load;
  logic pal_we;
  logic out_free;

  // shared column / count step unit
  logic [16:0]           col_inc;
  logic [15:0]           col_step;
  logic                  keep;
  logic [COUNT_BITS-1:0] kept_inc;
  logic [COUNT_BITS-1:0] total_cmp;
  logic                  done_now;

  logic        step_go;
  logic        push;
  logic        push_last;
  logic [23:0] pixel;

  assign in_stall  = (state_r != pcxrle_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_marker = (in_data.stream_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
  assign out_free  = !out_valid_r || !out_stall;

  // a stream byte that starts an expansion (literal or data byte of a run)
  assign load   = in_accept && !in_data.command && !finished_r && (run_pending_r || !is_marker);
  assign pal_we = in_accept && in_data.command && ({1'b0, in_data.entry_index} < PAL_LIMIT);

  assign keep      = column_r < image_width_r;
  assign col_inc   = {1'b0, column_r} + 17'd1;
  assign col_step  = (col_inc >= {1'b0, scanline_bytes_r}) ? 16'd0 : col_inc[15:0];
  assign kept_inc  = kept_count_r + COUNT_BITS'(1);
  assign total_cmp = COUNT_BITS'(total_bytes_r);
  assign done_now  = kept_inc == total_cmp;

  // pixel of the byte being expanded
  always_comb begin
    if (!palette_mode_r) begin
      pixel = {16'd0, byte_r};
    end else if ({1'b0, byte_r} < PAL_LIMIT) begin
      pixel = rd_r;
    end else begin
      pixel = 24'd0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcxrle_pkg::ST_IDLE: begin
        if (load) begin
          state_nxt = pcxrle_pkg::ST_RUN;
        end
      end
      pcxrle_pkg::ST_RUN: begin
        if (rem_r == 6'd0 && (!cand_valid_r || out_free)) begin
          state_nxt = pcxrle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcxrle_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    step_go   = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_r)
      pcxrle_pkg::ST_IDLE: begin
        step_go = 1'b0;
      end
      pcxrle_pkg::ST_RUN: begin
        if (rem_r != 6'd0) begin
          // a kept step forces out the held pixel, so it needs a free slot
          if (!keep || !cand_valid_r || out_free) begin
            step_go = 1'b1;
            push    = keep && cand_valid_r;
          end
        end else if (cand_valid_r && out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
      end
      default: step_go = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    run_pending_nxt = run_pending_r;
    run_count_nxt   = run_count_r;
    column_nxt      = column_r;
    kept_count_nxt  = kept_count_r;
    finished_nxt    = finished_r;
    rem_nxt         = rem_r;
    cand_valid_nxt  = cand_valid_r;
    cand_done_nxt   = cand_done_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;

    if (in_accept && !in_data.command && !finished_r) begin
      if (run_pending_r) begin
        run_pending_nxt = 1'b0;
        run_count_nxt   = 6'd0;
        rem_nxt         = run_count_r;
      end else if (is_marker) begin
        run_pending_nxt = 1'b1;
        run_count_nxt   = in_data.stream_byte[5:0] & pcxrle_pkg::RUN_LEN[5:0];
      end else begin
        rem_nxt = 6'd1;
      end
    end

    if (push) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.pixel_value = pixel;
      out_data_nxt.last        = push_last;
      out_data_nxt.image_done  = cand_done_r;
    end
    if (push_last) begin
      cand_valid_nxt = 1'b0;
    end

    if (step_go) begin
      column_nxt = col_step;
      rem_nxt    = rem_r - 6'd1;
      if (keep) begin
        kept_count_nxt = kept_inc;
        cand_valid_nxt = 1'b1;
        cand_done_nxt  = done_now;
        if (done_now) begin
          // image complete: drop the rest of the run
          finished_nxt = 1'b1;
          rem_nxt      = 6'd0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pcxrle_pkg::ST_IDLE;
      run_pending_r <= 1'b0;
      run_count_r   <= 6'd0;
      column_r      <= 16'd0;
      kept_count_r  <= '0;
      finished_r    <= 1'b0;
      rem_r         <= 6'd0;
      cand_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      run_pending_r <= run_pending_nxt;
      run_count_r   <= run_count_nxt;
      column_r      <= column_nxt;
      kept_count_r  <= kept_count_nxt;
      finished_r    <= finished_nxt;
      rem_r         <= rem_nxt;
      cand_valid_r  <= cand_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanline_bytes_r <= 16'd1;
      image_width_r    <= 16'd1;
      total_bytes_r    <= 24'd1;
      palette_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (pcxrle_pkg::cfg_reg_t'(cfg_addr))
        pcxrle_pkg::CFG_SCANLINE_BYTES: scanline_bytes_r <= cfg_wdata[15:0];
        pcxrle_pkg::CFG_IMAGE_WIDTH:    image_width_r    <= cfg_wdata[15:0];
        pcxrle_pkg::CFG_TOTAL_BYTES:    total_bytes_r    <= cfg_wdata[23:0];
        pcxrle_pkg::CFG_PALETTE_MODE:   palette_mode_r   <= cfg_wdata[0];
        default:                        palette_mode_r   <= palette_mode_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cand_done_r <= cand_done_nxt;
    out_data_r  <= out_data_nxt;
    if (load) begin
      byte_r <= in_data.stream_byte;
    end
  end

  // palette memory, read once per expanded byte
  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[in_data.entry_index[IDX_W-1:0]] <= in_data.entry_color;
    end
    if (load) begin
      rd_r <= palette_mem[in_data.stream_byte[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no pixel is held back while new input is taken
  a_idle_no_cand: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cand_valid_r)
    else $error("held pixel while accepting input");

  // the completing beat always closes its input beat
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.image_done |-> out_data_r.last)
    else $error("image_done without last");

  // completion is sticky until reset
  a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared");

  // expansion ends once the steps are used up and nothing is held
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pcxrle_pkg::ST_RUN && rem_r == 6'd0 && !cand_valid_r
    |=> state_r == pcxrle_pkg::ST_IDLE)
    else $error("sequencer failed to return to idle");

  // a new beat is never pushed over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !push)
    else $error("output beat overwritten under stall");

endmodule
